// ----- src/swhll_pkg.sv -----
// Shared types and constants for the sliding-window HyperLogLog sketch.
package swhll_pkg;

    localparam logic [62:0] SUM_MAX   = '1;
    localparam logic [10:0] EMPTY_MAX = '1;
    localparam logic [31:0] MW_RESET  = 32'd65536;
    localparam logic [5:0]  MAX_TERM_EXP = 6'd52;

    typedef struct packed {
        logic [31:0] ts;
        logic [5:0]  count;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LZC,
        S_ULEN,
        S_FWD_RD,
        S_FWD_CHK,
        S_EXP_SET,
        S_EXP_RD,
        S_EXP_CHK,
        S_CPY_RD,
        S_CPY_WR,
        S_FIN,
        S_Q_WAIT,
        S_Q_LEN,
        S_Q_RD,
        S_Q_CHK
    } t_state_a;

endpackage

// ----- src/sliding_window_hll_sketch.sv -----
// Sliding-window HyperLogLog sketch with per-register entry lists in one memory.
// An update first counts the leading zeros, then works through a list of L entries with a
// forward scan, an expiry scan and a copy pass on the single read port. A query visits
// each of the 2^PRECISION registers in turn, reading its in-window entries, and holds its
// end while the previous result is stalled. Reset first clears the list lengths of all
// 2^PRECISION registers.
module sliding_window_hll_sketch #(
    parameter int PRECISION  = 10,
    parameter int LIST_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_timestamp,
    input  logic [63:0] i_hash,
    input  logic [31:0] i_window,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [62:0] o_harmonic_sum,
    output logic [10:0] o_empty_registers
);
    import swhll_pkg::*;

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int SW = 53 + PRECISION;
    localparam int NREG = 1 << PRECISION;

    t_entry r_mem [NREG * (1 << IW)];
    logic [LW-1:0] r_len_mem [NREG];

    t_state_a r_state, n_state;
    logic [31:0] r_mw;
    logic [31:0] r_ts, n_ts;
    logic [31:0] r_win, n_win;
    logic [PRECISION-1:0] r_idx, n_idx;
    logic [63:0] r_rest, n_rest;
    logic [5:0] r_n, n_n;
    logic [5:0] r_c, n_c;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_k, n_k;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_j, n_j;
    logic r_drop, n_drop;
    logic [5:0] r_best, n_best;
    logic [SW-1:0] r_sum, n_sum;
    logic [PRECISION:0] r_empty, n_empty;
    logic r_ov, n_ov;
    logic [62:0] r_osum, n_osum;
    logic [10:0] r_oempty, n_oempty;

    t_entry r_rd;
    logic [LW-1:0] r_len_rd;
    logic [IW-1:0] rd_k, wr_k;
    logic mem_we, len_we;
    t_entry mem_wd;
    logic [LW-1:0] len_wd;

    logic [31:0] thr;
    logic [LW-1:0] src_k, dst_k;
    logic [SW-1:0] term;
    logic [32:0] reach;

    assign thr = r_ts - r_mw;
    assign src_k = (r_k == '0) ? LW'(r_cnt - LW'(1) - r_j) : LW'(r_k + r_j);
    assign dst_k = (r_k == '0) ? LW'(r_cnt - r_j) : LW'(r_j + LW'(1));
    assign term = (r_best <= MAX_TERM_EXP) ? (SW'(1) << (MAX_TERM_EXP - r_best)) : '0;
    assign reach = {1'b0, r_rd.ts} + {1'b0, r_win};
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_harmonic_sum = r_osum;
    assign o_empty_registers = r_oempty;

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[{r_idx, rd_k}];
        if (mem_we) begin
            r_mem[{r_idx, wr_k}] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_rd <= r_len_mem[r_idx];
        if (len_we) begin
            r_len_mem[r_idx] <= len_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_ov    <= 1'b0;
            r_mw    <= MW_RESET;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_mw <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts     <= n_ts;
        r_win    <= n_win;
        r_rest   <= n_rest;
        r_n      <= n_n;
        r_c      <= n_c;
        r_len    <= n_len;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_j      <= n_j;
        r_drop   <= n_drop;
        r_best   <= n_best;
        r_sum    <= n_sum;
        r_empty  <= n_empty;
        r_osum   <= n_osum;
        r_oempty <= n_oempty;
    end

    always_comb begin
        n_state  = r_state;
        n_ts     = r_ts;
        n_win    = r_win;
        n_idx    = r_idx;
        n_rest   = r_rest;
        n_n      = r_n;
        n_c      = r_c;
        n_len    = r_len;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_j      = r_j;
        n_drop   = r_drop;
        n_best   = r_best;
        n_sum    = r_sum;
        n_empty  = r_empty;
        n_ov     = r_ov && i_out_stall;
        n_osum   = r_osum;
        n_oempty = r_oempty;
        rd_k     = '0;
        wr_k     = '0;
        mem_we   = 1'b0;
        mem_wd   = '0;
        len_we   = 1'b0;
        len_wd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                len_we = 1'b1;
                if (&r_idx) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ts  = i_timestamp;
                    n_win = i_window;
                    if (i_mode) begin
                        n_idx   = '0;
                        n_sum   = '0;
                        n_empty = '0;
                        n_state = S_Q_WAIT;
                    end else begin
                        n_idx   = i_hash[63 -: PRECISION];
                        n_rest  = i_hash << PRECISION;
                        n_n     = '0;
                        n_state = S_LZC;
                    end
                end
            end
            S_LZC: begin
                if (r_rest == '0) begin
                    n_c     = 6'(65 - PRECISION);
                    n_state = S_ULEN;
                end else if (r_rest[63]) begin
                    n_c     = r_n + 6'd1;
                    n_state = S_ULEN;
                end else begin
                    n_rest = r_rest << 1;
                    n_n    = r_n + 6'd1;
                end
            end
            S_ULEN: begin
                n_len   = r_len_rd;
                n_k     = '0;
                n_state = S_FWD_RD;
            end
            S_FWD_RD: begin
                rd_k = r_k[IW-1:0];
                if (r_k == r_len) begin
                    n_state = S_EXP_SET;
                end else begin
                    n_state = S_FWD_CHK;
                end
            end
            S_FWD_CHK: begin
                if (r_rd.count <= r_c) begin
                    n_k     = LW'(r_k + LW'(1));
                    n_state = S_FWD_RD;
                end else begin
                    n_state = S_EXP_SET;
                end
            end
            S_EXP_SET: begin
                n_drop = 1'b0;
                n_j    = '0;
                if (r_k == '0 && r_len == LW'(LIST_DEPTH)) begin
                    n_cnt = LW'(r_len - LW'(1));
                end else begin
                    n_cnt = LW'(r_len - r_k);
                end
                if (r_ts < r_mw) begin
                    n_state = S_CPY_RD;
                end else begin
                    n_state = S_EXP_RD;
                end
            end
            S_EXP_RD: begin
                rd_k = IW'(r_k + r_cnt - LW'(1));
                if (r_cnt == '0) begin
                    n_drop  = (r_mw == '0);
                    n_state = S_CPY_RD;
                end else begin
                    n_state = S_EXP_CHK;
                end
            end
            S_EXP_CHK: begin
                if (r_rd.ts <= thr) begin
                    n_cnt   = LW'(r_cnt - LW'(1));
                    n_state = S_EXP_RD;
                end else begin
                    n_state = S_CPY_RD;
                end
            end
            S_CPY_RD: begin
                rd_k = src_k[IW-1:0];
                if (r_j == r_cnt) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CPY_WR;
                end
            end
            S_CPY_WR: begin
                mem_we  = 1'b1;
                wr_k    = dst_k[IW-1:0];
                mem_wd  = r_rd;
                n_j     = LW'(r_j + LW'(1));
                n_state = S_CPY_RD;
            end
            S_FIN: begin
                mem_we       = 1'b1;
                mem_wd.ts    = r_ts;
                mem_wd.count = r_c;
                len_we       = 1'b1;
                len_wd       = r_drop ? '0 : LW'(r_cnt + LW'(1));
                n_state      = S_IDLE;
            end
            S_Q_WAIT: begin
                n_state = S_Q_LEN;
            end
            S_Q_LEN: begin
                n_len  = r_len_rd;
                n_k    = '0;
                n_best = '0;
                if (r_len_rd == '0) begin
                    n_state = S_Q_CHK;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_Q_RD: begin
                rd_k    = r_k[IW-1:0];
                n_state = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (r_len != '0 && r_k != r_len && reach >= {1'b0, r_ts}) begin
                    n_best = r_rd.count;
                    n_k    = LW'(r_k + LW'(1));
                    if (LW'(r_k + LW'(1)) != r_len) begin
                        n_state = S_Q_RD;
                    end
                end else begin
                    n_sum   = r_sum + term;
                    n_empty = r_empty + (PRECISION + 1)'(r_best == '0);
                    if (!(&r_idx)) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_Q_WAIT;
                    end else if (!r_ov || !i_out_stall) begin
                        n_ov     = 1'b1;
                        n_osum   = (128'(r_sum + term) > 128'(SUM_MAX)) ? SUM_MAX :
                                   63'(r_sum + term);
                        n_oempty = (32'(r_empty + (PRECISION + 1)'(r_best == '0)) >
                                    32'(EMPTY_MAX)) ? EMPTY_MAX :
                                   11'(r_empty + (PRECISION + 1)'(r_best == '0));
                        n_state  = S_IDLE;
                    end else begin
                        n_sum   = r_sum;
                        n_empty = r_empty;
                        n_best  = r_best;
                        n_k     = r_len;
                        if (r_len == '0) begin
                            n_len = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_Q_CHK))
        else $error("Result appeared without a finished query.");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_cnt < LW'(LIST_DEPTH)))
        else $error("List length would exceed the list depth.");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (o_in_stall || $past(&r_idx)))
        else $error("Input accepted during the clearing pass.");

endmodule

// ----- bench/sliding_window_hll_sketch_test.sv -----
// Self-checking testbench for the sliding-window HyperLogLog sketch with its own sketch predictor.
module sliding_window_hll_sketch_test;
    import swhll_pkg::*;

    localparam int NREG       = 1024;
    localparam int DEPTH      = 64;
    localparam int COUNT_ZERO = 55;
    localparam int SETTLE     = 600;
    localparam int CYCLE_CAP  = 20000000;
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct {
        logic [62:0] sum;
        logic [10:0] empty;
    } t_estimate;

    typedef struct {
        logic        mode;
        logic [31:0] ts;
        logic [63:0] hash;
        logic [31:0] win;
        bit          typed;
        logic [62:0] sum;
        logic [10:0] empty;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_mode = 1'b0;
    logic [31:0] i_timestamp = '0;
    logic [63:0] i_hash = '0;
    logic [31:0] i_window = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [62:0] o_harmonic_sum;
    logic [10:0] o_empty_registers;

    sliding_window_hll_sketch dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_mode(i_mode), .i_timestamp(i_timestamp), .i_hash(i_hash), .i_window(i_window),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_harmonic_sum(o_harmonic_sum), .o_empty_registers(o_empty_registers)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] sk_time  [NREG][DEPTH];
    logic [5:0]  sk_count [NREG][DEPTH];
    int          sk_len   [NREG];
    logic [31:0] sk_max_window;
    t_estimate   estimates_due[$];
    bit          error_seen = 1'b0;
    int unsigned cycle_count = 0;
    logic [31:0] now;

    function automatic int rank_of(logic [63:0] h);
        logic [53:0] rest;
        rest = h[53:0];
        if (rest == '0) return COUNT_ZERO;
        for (int b = 53; b >= 0; b--) begin
            if (rest[b]) return 54 - b;
        end
        return COUNT_ZERO;
    endfunction

    task automatic sketch_insert(logic [31:0] ts, logic [63:0] h);
        int          idx;
        int          c;
        int          n;
        logic [31:0] nt [DEPTH+1];
        logic [5:0]  nc [DEPTH+1];
        logic [31:0] thr;
        idx = int'(h[63:54]);
        c = rank_of(h);
        nt[0] = ts;
        nc[0] = 6'(c);
        n = 1;
        for (int k = 0; k < sk_len[idx]; k++) begin
            if (int'(sk_count[idx][k]) > c) begin
                nt[n] = sk_time[idx][k];
                nc[n] = sk_count[idx][k];
                n++;
            end
        end
        if (n > DEPTH) n = DEPTH;
        if (ts >= sk_max_window) begin
            thr = ts - sk_max_window;
            while (n > 0 && nt[n-1] <= thr) n--;
        end
        for (int k = 0; k < n; k++) begin
            sk_time[idx][k] = nt[k];
            sk_count[idx][k] = nc[k];
        end
        sk_len[idx] = n;
    endtask

    function automatic t_estimate sketch_estimate(logic [31:0] ts, logic [31:0] win);
        t_estimate   r;
        logic [63:0] acc;
        int          best;
        int          empty;
        acc = '0;
        empty = 0;
        for (int g = 0; g < NREG; g++) begin
            best = 0;
            for (int k = 0; k < sk_len[g]; k++) begin
                if ({1'b0, sk_time[g][k]} + {1'b0, win} < {1'b0, ts}) break;
                best = int'(sk_count[g][k]);
            end
            if (best == 0) empty++;
            if (best <= 52) acc += 64'd1 << (52 - best);
        end
        r.sum = (acc > 64'(SUM_MAX)) ? SUM_MAX : acc[62:0];
        r.empty = (empty > 2047) ? EMPTY_MAX : 11'(empty);
        return r;
    endfunction

    // Drives one word and returns at the edge that accepts it, with valid still high.
    task automatic send_word(t_row w);
        t_estimate e;
        i_in_valid  <= 1'b1;
        i_mode      <= w.mode;
        i_timestamp <= w.ts;
        i_hash      <= w.hash;
        i_window    <= w.win;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (w.mode == MODE_UPDATE) begin
            sketch_insert(w.ts, w.hash);
        end else begin
            e = sketch_estimate(w.ts, w.win);
            if (w.typed) begin
                e.sum = w.sum;
                e.empty = w.empty;
            end
            estimates_due.insert(estimates_due.size(), e);
        end
    endtask

    task automatic pause_sender(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_window(logic [31:0] v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (estimates_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sk_max_window = v;
    endtask

    function automatic logic [63:0] hash_for(int idx, int c);
        logic [63:0] h;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        h = '0;
        h[63:54] = 10'(idx);
        if (c <= 54) begin
            h[54-c] = 1'b1;
            h[53:0] = h[53:0] | 54'(noise & ((64'd1 << (54 - c)) - 64'd1));
        end
        return h;
    endfunction

    function automatic logic [31:0] pick_window();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    // Mostly descending-rank runs on a few busy registers so lists grow deep.
    task automatic random_phase(int items);
        t_row w;
        int   sent;
        int   burst;
        int   hot;
        int   c;
        sent = 0;
        burst = $urandom_range(1, 20);
        hot = 0;
        c = 0;
        while (sent < items) begin
            w.typed = 1'b0;
            w.sum = '0;
            w.empty = '0;
            if ($urandom_range(0, 19) == 0) now = $urandom;
            else now = now + $urandom_range(0, 40);
            w.ts = now;
            w.hash = {$urandom, $urandom};
            w.win = $urandom;
            if ($urandom_range(0, 9) == 0) begin
                w.mode = MODE_QUERY;
                w.win = pick_window();
            end else begin
                w.mode = MODE_UPDATE;
                if (c <= 1 || $urandom_range(0, 15) == 0) begin
                    hot = $urandom_range(0, 7) * 131;
                    c = $urandom_range(20, COUNT_ZERO + 1);
                end
                if ($urandom_range(0, 4) != 0) begin
                    c = c - $urandom_range(1, 2);
                    if (c < 1) c = 1;
                    w.hash = hash_for(hot, c);
                end
            end
            send_word(w);
            sent++;
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 30));
            end
        end
    endtask

    t_row directed_rows[] = '{
        '{MODE_QUERY,  32'd0, 64'd0, 32'd0, 1'b1, 63'h4000_0000_0000_0000, 11'd1024},
        '{MODE_UPDATE, 32'd0, 64'd0, 32'd0, 1'b0, '0, '0},
        '{MODE_UPDATE, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, '0, '0},
        '{MODE_UPDATE, 32'd2, {10'd5, 54'd0}, 32'd0, 1'b0, '0, '0},
        '{MODE_UPDATE, 32'd3, {10'd5, 1'b1, 53'd0}, 32'd0, 1'b0, '0, '0},
        '{MODE_QUERY,  32'd3, 64'd0, 32'd0, 1'b0, '0, '0},
        '{MODE_QUERY,  32'd3, 64'd0, 32'hFFFF_FFFF, 1'b0, '0, '0},
        '{MODE_UPDATE, 32'd10, {10'd7, 54'd1}, 32'd0, 1'b0, '0, '0},
        '{MODE_UPDATE, 32'd11, {10'd7, 54'd2}, 32'd0, 1'b0, '0, '0},
        '{MODE_UPDATE, 32'd12, {10'd7, 54'd3}, 32'd0, 1'b0, '0, '0},
        '{MODE_QUERY,  32'd12, 64'd0, 32'd1, 1'b0, '0, '0},
        '{MODE_UPDATE, 32'hFFFF_FFFF, {10'd0, 1'b1, 53'd0}, 32'd0, 1'b0, '0, '0},
        '{MODE_QUERY,  32'hFFFF_FFFF, 64'd0, 32'd0, 1'b0, '0, '0},
        '{MODE_QUERY,  32'hFFFF_FFFF, 64'd0, 32'hFFFF_FFFF, 1'b0, '0, '0},
        '{MODE_QUERY,  32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, '0, '0}
    };

    always @(posedge i_clk) begin
        logic [2:0] phase;
        phase = 3'(cycle_count >> 9);
        case (phase)
            3'd0, 3'd4: i_out_stall <= 1'b0;
            3'd1:       i_out_stall <= 1'($urandom_range(0, 1));
            3'd2:       i_out_stall <= (cycle_count % 7) < 4;
            3'd3:       i_out_stall <= (cycle_count % 300) < 250;
            default:    i_out_stall <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        t_estimate e;
        if (o_out_valid && !i_out_stall) begin
            if (estimates_due.size() == 0) begin
                $display("%0t: unexpected word sum=%h empty=%0d", $time,
                         o_harmonic_sum, o_empty_registers);
                error_seen = 1'b1;
            end else begin
                e = estimates_due.pop_front();
                if (o_harmonic_sum !== e.sum) begin
                    $display("%0t: harmonic_sum expected %h actual %h", $time,
                             e.sum, o_harmonic_sum);
                    error_seen = 1'b1;
                end
                if (o_empty_registers !== e.empty) begin
                    $display("%0t: empty_registers expected %0d actual %0d", $time,
                             e.empty, o_empty_registers);
                    error_seen = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("sliding_window_hll_sketch_test: FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] settings [5];
        sk_max_window = MW_RESET;
        for (int g = 0; g < NREG; g++) sk_len[g] = 0;
        now = 32'd100;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[i]) send_word(directed_rows[i]);
        pause_sender(3);
        settings = '{32'd1, 32'hFFFF_FFFF, 32'd100, $urandom_range(1, 5000), MW_RESET};
        random_phase(110);
        for (int p = 0; p < 5; p++) begin
            write_window(settings[p]);
            now = $urandom_range(0, 100000);
            random_phase(90);
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (estimates_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (error_seen) begin
            $display("sliding_window_hll_sketch_test: FAIL");
        end else begin
            $display("sliding_window_hll_sketch_test: PASS");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/swhll_pkg.sv
src/sliding_window_hll_sketch.sv
bench/sliding_window_hll_sketch_test.sv
